// ===== hdl/sha224_stream_hasher_defines.svh =====
// Assertion helpers shared by the hasher RTL.
// Both macros sample on the rising edge of clock and are disabled during reset.
`ifndef SHA224_STREAM_HASHER_DEFINES_SVH
`define SHA224_STREAM_HASHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA224_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA224_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sha224_pkg.sv =====
package sha224_pkg;

   // Block geometry and padding layout.
   localparam int BLOCK_BYTES  = 64;
   localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
   localparam int ROUNDS       = 64;
   localparam int DIGEST_WORDS = 224 / 32;
   localparam int LEN_START    = BLOCK_BYTES - 8;
   localparam int COUNT_BITS   = 61;
   localparam int LEN_BITS     = COUNT_BITS + 3;

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0]          word_type;
   typedef word_type [0:7]       hash_type;
   typedef logic [5:0]           round_type;
   typedef logic [5:0]           fill_type;
   typedef logic [2:0]           word_idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [LEN_BITS-1:0]  len_type;

   localparam word_idx_type LAST_WORD_IDX = word_idx_type'(DIGEST_WORDS - 1);
   localparam fill_type     LAST_FILL     = fill_type'(BLOCK_BYTES - 1);
   localparam round_type    LAST_ROUND    = round_type'(ROUNDS - 1);

   // Initial chaining values for the 224-bit variant.
   localparam hash_type INIT_H = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   // Round constants.
   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_FINISH,
      ST_DIGEST
   } state_type;

   // Controls from the sequencer to the round unit.
   typedef struct packed {
      logic load;
      logic step;
   } round_ctrl_type;

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== hdl/sha224_req_if.sv =====
interface sha224_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last_item;

   modport source (output valid, data_byte, byte_present, last_item, input ready);
   modport sink (input valid, data_byte, byte_present, last_item, output ready);
endinterface

// ===== hdl/sha224_rsp_if.sv =====
interface sha224_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha224_round_core.sv =====
module sha224_round_core
   import sha224_pkg::*;
(
   input  logic           clock,
   input  round_ctrl_type ctrl,
   input  hash_type       chain,
   input  word_type       w,
   input  word_type       k,
   output hash_type       work
);

   hash_type work_ff;
   hash_type work_in;
   word_type t1;
   word_type t2;

   // One compression round per step; load copies the chaining state in.
   always_comb begin
      t1 = work_ff[7] + big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) + k + w;
      t2 = big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
      work_in = work_ff;
      priority if (ctrl.load) begin
         work_in = chain;
      end else if (ctrl.step) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

// ===== hdl/sha224_stream_hasher.sv =====
// One message byte is taken per cycle while a block fills; the 64th byte of a block holds
// the request side off while the shared round unit runs 64 rounds and the chaining add is
// done. A last request pads one byte per cycle to the block end and compresses, padding a
// second block when the length does not fit; the seven digest words then leave one per
// cycle when taken. Synchronous reset restores the initial chain and clears the fill,
// message, round and word counts.
`include "sha224_stream_hasher_defines.svh"

module sha224_stream_hasher
   import sha224_pkg::*;
(
   input logic          clock,
   input logic          reset,
   sha224_req_if.sink   req_if,
   sha224_rsp_if.source rsp_if
);

   localparam int W_MSB = BLOCK_BITS - 1;

   state_type              state_ff, state_in;
   fill_type               fill_ff, fill_in;
   count_type              msg_count_ff, msg_count_in;
   len_type                len_ff, len_in;
   logic [BLOCK_BITS-1:0]  window_ff, window_in;
   hash_type               chain_ff, chain_in;
   round_type              round_ff, round_in;
   logic                   pad_active_ff, pad_active_in;
   logic                   mark_sent_ff, mark_sent_in;
   logic                   final_blk_ff, final_blk_in;
   word_idx_type           out_idx_ff, out_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_word_ff, rsp_word_in;
   word_idx_type           rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;

   round_ctrl_type         round_ctrl;
   hash_type               work;
   word_type               sched_w;
   word_type               sched_new;
   logic                   req_accept;
   logic                   digest_load;

   // Current schedule word and the next one, taken from fixed words of the window.
   assign sched_w   = window_ff[W_MSB -: 32];
   assign sched_new = small_sigma1(window_ff[W_MSB - 14 * 32 -: 32])
                    + window_ff[W_MSB - 9 * 32 -: 32]
                    + small_sigma0(window_ff[W_MSB - 32 -: 32])
                    + window_ff[W_MSB -: 32];

   sha224_round_core u_round (
      .clock (clock),
      .ctrl  (round_ctrl),
      .chain (chain_ff),
      .w     (sched_w),
      .k     (ROUND_K[round_ff]),
      .work  (work)
   );

   // The request side is open only while the sequencer waits for bytes.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   // Sequencer: byte collection, padding, compression rounds and digest readout.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      msg_count_in  = msg_count_ff;
      len_in        = len_ff;
      window_in     = window_ff;
      chain_in      = chain_ff;
      round_in      = round_ff;
      pad_active_in = pad_active_ff;
      mark_sent_in  = mark_sent_ff;
      final_blk_in  = final_blk_ff;
      out_idx_in    = out_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      round_ctrl    = '0;
      digest_load   = 1'b0;

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.byte_present) begin
                  window_in    = {window_ff[W_MSB-8:0], req_if.data_byte};
                  fill_in      = fill_ff + fill_type'(1);
                  msg_count_in = msg_count_ff + count_type'(1);
               end
               if (req_if.last_item) begin
                  len_in        = {msg_count_in, 3'b000};
                  pad_active_in = 1'b1;
                  mark_sent_in  = 1'b0;
                  final_blk_in  = 1'b0;
               end
               if (req_if.byte_present && fill_ff == LAST_FILL) begin
                  round_ctrl.load = 1'b1;
                  round_in        = '0;
                  state_in        = ST_COMPRESS;
               end else if (req_if.last_item) begin
                  state_in = ST_PAD;
               end
            end
         end

         ST_PAD: begin
            // One pad byte per cycle: the mark, zero fill, then the bit length.
            if (!mark_sent_ff) begin
               window_in    = {window_ff[W_MSB-8:0], PAD_MARK};
               mark_sent_in = 1'b1;
               final_blk_in = final_blk_ff || (fill_ff < fill_type'(LEN_START));
            end else if (final_blk_ff && fill_ff >= fill_type'(LEN_START)) begin
               window_in = {window_ff[W_MSB-8:0], len_ff[LEN_BITS-1 -: 8]};
               len_in    = {len_ff[LEN_BITS-9:0], 8'h00};
            end else begin
               window_in = {window_ff[W_MSB-8:0], 8'h00};
            end
            fill_in = fill_ff + fill_type'(1);
            if (fill_ff == LAST_FILL) begin
               round_ctrl.load = 1'b1;
               round_in        = '0;
               state_in        = ST_COMPRESS;
            end
         end

         ST_COMPRESS: begin
            // The window doubles as the rolling message schedule.
            round_ctrl.step = 1'b1;
            window_in       = {window_ff[W_MSB-32:0], sched_new};
            round_in        = round_ff + round_type'(1);
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work[i];
            end
            priority if (pad_active_ff && final_blk_ff) begin
               out_idx_in = '0;
               state_in   = ST_DIGEST;
            end else if (pad_active_ff) begin
               final_blk_in = 1'b1;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_DIGEST: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               digest_load  = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_idx_ff];
               rsp_idx_in   = out_idx_ff;
               rsp_last_in  = (out_idx_ff == LAST_WORD_IDX);
               out_idx_in   = out_idx_ff + word_idx_type'(1);
               if (out_idx_ff == LAST_WORD_IDX) begin
                  // Last word is held in the output register; start a new message.
                  chain_in      = INIT_H;
                  msg_count_in  = '0;
                  fill_in       = '0;
                  pad_active_in = 1'b0;
                  mark_sent_in  = 1'b0;
                  final_blk_in  = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         msg_count_ff  <= '0;
         chain_ff      <= INIT_H;
         round_ff      <= '0;
         pad_active_ff <= 1'b0;
         mark_sent_ff  <= 1'b0;
         final_blk_ff  <= 1'b0;
         out_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         msg_count_ff  <= msg_count_in;
         chain_ff      <= chain_in;
         round_ff      <= round_in;
         pad_active_ff <= pad_active_in;
         mark_sent_ff  <= mark_sent_in;
         final_blk_ff  <= final_blk_in;
         out_idx_ff    <= out_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      window_ff   <= window_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digest_word = rsp_word_ff;
   assign rsp_if.word_index  = rsp_idx_ff;
   assign rsp_if.last_word   = rsp_last_ff;

   // Compression only starts on a completely filled block.
   `SHA224_ASSERT_NOW(a_compress_full, state_ff == ST_COMPRESS && round_ff == '0, fill_ff == '0, "compression started on a partial block")

   // Length bytes are written only after the pad mark.
   `SHA224_ASSERT_NOW(a_len_after_mark, state_ff == ST_PAD && final_blk_ff && fill_ff >= fill_type'(LEN_START), mark_sent_ff, "length bytes written without the pad mark")

   // Digest readout only follows the final padded block.
   `SHA224_ASSERT_NOW(a_digest_final, state_ff == ST_DIGEST, pad_active_ff && final_blk_ff, "digest readout outside a finished message")

   // After the seventh word is loaded the hasher is back in its reset state.
   `SHA224_ASSERT_NEXT(a_restart, digest_load && out_idx_ff == LAST_WORD_IDX, chain_ff == INIT_H && msg_count_ff == '0 && state_ff == ST_IDLE, "hasher did not restart after the digest")

endmodule
